FILE: rtl/art_pkg.sv
// Shared types and constants for the address region table.
`timescale 1ns / 1ps

package art_pkg;

    localparam int REGION_COUNT_DEF = 16;
    localparam int PAGE_SHIFT_DEF   = 12;
    localparam int ADDR_WIDTH_DEF   = 32;

    localparam int FIELD_W   = 32;
    localparam int POFF_W    = 12;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 144;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_NOT_FOUND = 3'd1,
        STATUS_OVERLAP   = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_WRAP      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] file_offset;
        logic [FIELD_W-1:0] length;
        logic [POFF_W-1:0]  page_offset;
        logic [FIELD_W-1:0] region_end;
        logic [FIELD_W-1:0] region_start;
        status_t            status;
    } res_t;

endpackage

FILE: rtl/art_cmp.sv
// Shared range compare unit: half-open interval intersection against one entry.
`timescale 1ns / 1ps

module art_cmp #(
    parameter int EW = 32
) (
    input  logic [EW-1:0] lo,
    input  logic [EW:0]   hi,
    input  logic [EW-1:0] ent_start,
    input  logic [EW-1:0] ent_end,
    output logic          hit
);

    // A point lookup uses [addr, addr+1), which reduces to start <= addr < end.
    assign hit = (lo < ent_end) && ({1'b0, ent_start} < hi);

endmodule

FILE: rtl/art_seq.sv
// Scan sequencer: entry memory, valid bits, and per-request control.
`timescale 1ns / 1ps

module art_seq
    #(
    parameter int REGION_COUNT = art_pkg::REGION_COUNT_DEF,
    parameter int PAGE_SHIFT   = art_pkg::PAGE_SHIFT_DEF,
    parameter int ADDR_WIDTH   = art_pkg::ADDR_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [art_pkg::KIND_W-1:0]   in_kind,
    input  logic [art_pkg::FIELD_W-1:0]  in_addr,
    input  logic [art_pkg::FIELD_W-1:0]  in_len,
    input  logic [art_pkg::FIELD_W-1:0]  in_foff,
    output logic                         res_valid,
    input  logic                         res_ready,
    output art_pkg::res_t                res
);

    import art_pkg::*;

    localparam int EW   = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int IW   = $clog2(REGION_COUNT);
    localparam int OW   = (PAGE_SHIFT < 12) ? PAGE_SHIFT : 12;
    localparam int S_LO = 0;
    localparam int E_LO = EW;
    localparam int P_LO = 2 * EW;
    localparam int L_LO = P_LO + POFF_W;
    localparam int F_LO = L_LO + FIELD_W;
    localparam int MW   = F_LO + FIELD_W;
    localparam logic [IW-1:0] LAST = IW'(REGION_COUNT - 1);
    localparam logic [EW-1:0] PMASK = {{(EW - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    localparam logic [EW-1:0] AMASK = {EW{1'b1}};

    logic [MW-1:0] mem [REGION_COUNT];

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [REGION_COUNT-1:0] valid_reg, valid_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic              issue_reg, issue_next;
    logic              live_reg, live_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              q_valid_reg, q_valid_next;
    logic [IW-1:0]     free_reg, free_next;
    logic              free_found_reg, free_found_next;

    logic [MW-1:0]     q_data_reg;
    logic [EW-1:0]     lo_reg, lo_next;
    logic [EW:0]       hi_reg, hi_next;
    logic [POFF_W-1:0] poff_reg, poff_next;
    logic [FIELD_W-1:0] len_reg, len_next;
    logic [FIELD_W-1:0] foff_reg, foff_next;
    res_t              res_reg, res_next;

    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    logic [MW-1:0]     mem_wd;

    logic [EW-1:0]     addr_m;
    logic [EW-1:0]     start_c;
    logic [33:0]       sum_c;
    logic [33:0]       end_c;
    logic              wrap_c;

    logic [EW-1:0]     q_start;
    logic [EW-1:0]     q_end;
    logic              cmp_hit;
    logic              hit;
    logic              cur_free;
    logic              last;
    logic [IW-1:0]     ins_slot;
    res_t              q_res;
    res_t              new_res;
    res_t              fail_res;

    assign q_start = q_data_reg[S_LO +: EW];
    assign q_end   = q_data_reg[E_LO +: EW];

    art_cmp #(
        .EW (EW)
    ) u_cmp (
        .lo        (lo_reg),
        .hi        (hi_reg),
        .ent_start (q_start),
        .ent_end   (q_end),
        .hit       (cmp_hit)
    );

    assign addr_m  = in_addr[EW-1:0];
    assign start_c = addr_m & ~PMASK;
    assign sum_c   = 34'(addr_m) + 34'(in_len) + 34'(PMASK);
    assign end_c   = sum_c & ~34'(PMASK);
    assign wrap_c  = end_c > 34'(AMASK);

    assign hit      = live_reg && q_valid_reg && cmp_hit;
    assign cur_free = live_reg && !q_valid_reg;
    assign last     = live_reg && (cmp_idx_reg == LAST);
    assign ins_slot = free_found_reg ? free_reg : cmp_idx_reg;

    always_comb
    begin
        q_res              = '0;
        q_res.status       = STATUS_OK;
        q_res.region_start = 32'(q_start);
        q_res.region_end   = 32'(q_end);
        q_res.page_offset  = q_data_reg[P_LO +: POFF_W];
        q_res.length       = q_data_reg[L_LO +: FIELD_W];
        q_res.file_offset  = q_data_reg[F_LO +: FIELD_W];

        new_res              = '0;
        new_res.status       = STATUS_OK;
        new_res.region_start = 32'(lo_reg);
        new_res.region_end   = 32'(hi_reg[EW-1:0]);
        new_res.page_offset  = poff_reg;
        new_res.length       = len_reg;
        new_res.file_offset  = foff_reg;

        fail_res        = '0;
        fail_res.status = STATUS_NOT_FOUND;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        issue_next      = issue_reg;
        live_next       = live_reg;
        cmp_idx_next    = cmp_idx_reg;
        q_valid_next    = q_valid_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        poff_next       = poff_reg;
        len_next        = len_reg;
        foff_next       = foff_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_wa          = ins_slot;
        mem_wd          = {foff_reg, len_reg, poff_reg, hi_reg[EW-1:0], lo_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind_t'(in_kind);
                    poff_next       = POFF_W'(addr_m[OW-1:0]);
                    len_next        = in_len;
                    foff_next       = in_foff;
                    rd_idx_next     = '0;
                    issue_next      = 1'b1;
                    live_next       = 1'b0;
                    free_found_next = 1'b0;
                    res_next        = fail_res;
                    state_next      = S_SCAN;
                    case (kind_t'(in_kind))
                        KIND_LOOKUP, KIND_REMOVE:
                        begin
                            lo_next = addr_m;
                            hi_next = {1'b0, addr_m} + {{EW{1'b0}}, 1'b1};
                        end
                        KIND_INSERT:
                        begin
                            lo_next = start_c;
                            hi_next = {1'b0, end_c[EW-1:0]};
                            if (wrap_c)
                            begin
                                res_next.status = STATUS_WRAP;
                                issue_next      = 1'b0;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            issue_next = 1'b0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read stage runs one slot ahead of the compare stage
                live_next    = issue_reg;
                cmp_idx_next = rd_idx_reg;
                q_valid_next = valid_reg[rd_idx_reg];
                if (issue_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    issue_next  = (rd_idx_reg != LAST);
                end

                if (kind_reg == KIND_INSERT)
                begin
                    if (hit)
                    begin
                        res_next.status = STATUS_OVERLAP;
                        issue_next      = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        if (cur_free && !free_found_reg)
                        begin
                            free_next       = cmp_idx_reg;
                            free_found_next = 1'b1;
                        end
                        if (last)
                        begin
                            if (free_found_reg || cur_free)
                            begin
                                mem_we               = 1'b1;
                                valid_next[ins_slot] = 1'b1;
                                res_next             = new_res;
                            end
                            else
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            state_next = S_DONE;
                        end
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        res_next   = q_res;
                        issue_next = 1'b0;
                        state_next = S_DONE;
                        if (kind_reg == KIND_REMOVE)
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                        end
                    end
                    else if (last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= KIND_LOOKUP;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            issue_reg      <= 1'b0;
            live_reg       <= 1'b0;
            cmp_idx_reg    <= '0;
            q_valid_reg    <= 1'b0;
            free_reg       <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            valid_reg      <= valid_next;
            rd_idx_reg     <= rd_idx_next;
            issue_reg      <= issue_next;
            live_reg       <= live_next;
            cmp_idx_reg    <= cmp_idx_next;
            q_valid_reg    <= q_valid_next;
            free_reg       <= free_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        poff_reg <= poff_next;
        len_reg  <= len_next;
        foff_reg <= foff_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        q_data_reg <= mem[rd_idx_reg];
    end

endmodule

FILE: rtl/address_region_table.sv
// Top level of the address region table: stream ports and output register.
`timescale 1ns / 1ps

// Holds up to REGION_COUNT disjoint, page-aligned address regions in an
// entry memory with one write port and one read port. Every request walks the
// slots in order through one range comparator, one slot per cycle with a
// registered memory read (lookup and remove stop at the first hit, an insert
// that overlaps stops at the overlapping slot; an unknown kind or a wrapping
// insert goes straight to its result without a walk). One request is worked
// at a time; the finished result sits in an output register so the next
// request can be taken while it waits. Inserts go into the lowest free slot.
// Failed requests return zero region fields.

module address_region_table
    #(
    parameter int REGION_COUNT = art_pkg::REGION_COUNT_DEF,
    parameter int PAGE_SHIFT   = art_pkg::PAGE_SHIFT_DEF,
    parameter int ADDR_WIDTH   = art_pkg::ADDR_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // addr[31:0], len[63:32], file_offset[95:64]
    input  logic [art_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [art_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // region_start[31:0], region_end[63:32], region_page_offset[75:64],
    // region_length[107:76], region_file_offset[139:108], zero[143:140]
    output logic [art_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[2:0]
    output logic [art_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import art_pkg::*;

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    art_seq #(
        .REGION_COUNT (REGION_COUNT),
        .PAGE_SHIFT   (PAGE_SHIFT),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_addr   (s_axis_tdata[31:0]),
        .in_len    (s_axis_tdata[63:32]),
        .in_foff   (s_axis_tdata[95:64]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {4'b0000, out_reg.file_offset, out_reg.length,
                            out_reg.page_offset, out_reg.region_end,
                            out_reg.region_start};

endmodule

FILE: rtl/art_checker.sv
// Port-level checks for the address region table, bound to the top level.
`timescale 1ns / 1ps

module art_checker
    #(
    parameter int PAGE_SHIFT = art_pkg::PAGE_SHIFT_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [art_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic [art_pkg::KIND_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [art_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [art_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import art_pkg::*;

    // a result stalled by the sink stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= STATUS_WRAP))
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
        else $error("failed request returned region data");

    a_ok_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_OK)
        |-> (m_axis_tdata[PAGE_SHIFT-1:0] == '0) && (m_axis_tdata[32 +: PAGE_SHIFT] == '0))
        else $error("region bounds not page aligned");

endmodule

bind address_region_table art_checker #(
    .PAGE_SHIFT (PAGE_SHIFT)
) u_art_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
